// ----- rtl/core/spl_pkg.sv -----
// package for the stereo peak limiter: payload types, register indexes, sequencer states
`timescale 1ns / 1ps
`default_nettype none
package spl_pkg;
	localparam int SampleW = 24;
	localparam int RegW    = 24;
	localparam int CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] REG_INPUT_GAIN  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_OUTPUT_GAIN = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_THRESHOLD   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_ATTACK      = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_RELEASE     = 3'd4;

	typedef struct packed {
		logic signed [SampleW-1:0] left_in;
		logic signed [SampleW-1:0] right_in;
	} in_item_t;

	typedef struct packed {
		logic signed [SampleW-1:0] left_out;
		logic signed [SampleW-1:0] right_out;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GAIN_IN,
		ST_ENV,
		ST_CMP,
		ST_DIV,
		ST_SCALE,
		ST_GAIN_OUT,
		ST_DONE,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

// ----- rtl/core/stereo_peak_limiter_unit.sv -----
// stereo peak limiter top level with one shared multiplier and a serial divider
//
// usage:
//  - in channel: in_valid/in_stall carry one stereo item (left_in, right_in)
//  - out channel: out_valid/out_stall carry the limited item (left_out, right_out)
//  - cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data; writes are
//    taken in any cycle and must only be made while the block is idle
//  - the two channels are worked one after the other through one multiplier
//    and a restoring divider that settles one quotient bit a cycle
//  - per channel the steps are input gain, envelope, threshold compare and
//    output gain; limiting adds the divider and a scale step before output gain
//  - an item runs the left channel, a done step, the right channel and an output
//    step; the next item is taken only once the sequencer is idle again
//  - in_stall is high from acceptance until the sequencer is idle again
//  - while a result waits on out_stall the next item is taken and worked; it
//    holds in the right channel's output gain step until the register is free
//  - reset clears the envelopes, restores the register reset values and
//    empties the output register
`timescale 1ns / 1ps
`default_nettype none
module stereo_peak_limiter_unit
	import spl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_item_t             in_item,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_item_t                 out_item,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CfgIdxW-1:0]   cfg_index,
	input  wire logic [RegW-1:0]      cfg_data
);
	localparam int EnvW = SampleW + 4;
	localparam int DivW = 24;

	state_t state_q, state_d;
	logic [RegW-1:0] in_gain_q, out_gain_q, thr_q, att_q, rel_q;
	logic [EnvW-1:0] env_q [2];
	logic            ch_q;
	logic            neg_q;
	logic [EnvW-1:0] mag_q;
	logic [EnvW-1:0] env_new_q;
	logic [DivW-1:0] quo_q;
	logic [EnvW:0]   rem_q;
	logic [4:0]      cnt_q;
	logic [SampleW-1:0] res0_q;
	out_item_t       out_q;
	logic            out_valid_q;
	logic signed [SampleW-1:0] in_left_q, in_right_q;

	// shared multiplier
	logic [EnvW-1:0] mul_a;
	logic [RegW-1:0] mul_b;
	logic [EnvW+RegW-1:0] mul_p;
	assign mul_p = mul_a * mul_b;

	logic [SampleW-1:0] x_raw;
	logic [SampleW-1:0] x_mag;
	logic [EnvW-1:0] env_cur, diff;
	logic            rising;
	logic [EnvW+RegW-1:0] mag_gain, y_full, env_adj, scaled;
	logic [EnvW-1:0] env_new;
	logic [SampleW-1:0] y_sat;
	logic [EnvW:0]   rem_sh;
	logic            out_free;

	assign x_raw   = ch_q ? in_right_q : in_left_q;
	assign x_mag   = x_raw[SampleW-1] ? (~x_raw + 1'b1) : x_raw;
	assign env_cur = env_q[ch_q];
	assign rising  = mag_q > env_cur;
	assign diff    = rising ? (mag_q - env_cur) : (env_cur - mag_q);
	assign rem_sh  = {rem_q[EnvW-1:0], 1'b0};
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		mul_a = mag_q;
		mul_b = out_gain_q;
		unique case (state_q)
			ST_GAIN_IN: begin
				mul_a = EnvW'(x_mag);
				mul_b = in_gain_q;
			end
			ST_ENV: begin
				mul_a = diff;
				mul_b = rising ? att_q : rel_q;
			end
			ST_SCALE: begin
				mul_a = mag_q;
				mul_b = quo_q;
			end
			default: begin
				mul_a = mag_q;
				mul_b = out_gain_q;
			end
		endcase
	end

	assign mag_gain = (mul_p + (EnvW+RegW)'(1 << 19)) >> 20;
	assign env_adj  = (mul_p + (EnvW+RegW)'(1 << 23)) >> 24;
	assign scaled   = env_adj;
	assign y_full   = mag_gain;
	assign env_new  = rising ? (mag_q - env_adj[EnvW-1:0]) : (mag_q + env_adj[EnvW-1:0]);

	always_comb begin
		if (neg_q) begin
			y_sat = (y_full > (EnvW+RegW)'(1 << (SampleW-1)))
				? SampleW'(1 << (SampleW-1))
				: SampleW'(~y_full[SampleW-1:0] + 1'b1);
		end else begin
			y_sat = (y_full > (EnvW+RegW)'((1 << (SampleW-1)) - 1))
				? SampleW'((1 << (SampleW-1)) - 1)
				: y_full[SampleW-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_GAIN_IN;
			ST_GAIN_IN:  state_d = ST_ENV;
			ST_ENV:      state_d = ST_CMP;
			ST_CMP:      state_d = (env_new_q > EnvW'(thr_q)) ? ST_DIV : ST_GAIN_OUT;
			ST_DIV:      if (cnt_q == 5'(DivW-1)) state_d = ST_SCALE;
			ST_SCALE:    state_d = ST_GAIN_OUT;
			ST_GAIN_OUT: begin
				if (!ch_q)         state_d = ST_DONE;
				else if (out_free) state_d = ST_OUT;
			end
			ST_DONE:     state_d = ST_GAIN_IN;
			ST_OUT:      state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		cfg_ready = 1'b1;
		out_valid = out_valid_q;
		out_item  = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_gain_q   <= RegW'(1048576);
			out_gain_q  <= RegW'(1048576);
			thr_q       <= RegW'(7919344);
			att_q       <= RegW'(16617027);
			rel_q       <= RegW'(16773997);
			env_q[0]    <= '0;
			env_q[1]    <= '0;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_INPUT_GAIN:  in_gain_q  <= cfg_data;
					REG_OUTPUT_GAIN: out_gain_q <= cfg_data;
					REG_THRESHOLD:   thr_q      <= cfg_data;
					REG_ATTACK:      att_q      <= cfg_data;
					REG_RELEASE:     rel_q      <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:  ch_q <= 1'b0;
				ST_ENV:   env_q[ch_q] <= env_new;
				ST_DONE:  ch_q <= 1'b1;
				ST_OUT:   out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				in_left_q  <= in_item.left_in;
				in_right_q <= in_item.right_in;
			end
			ST_GAIN_IN: begin
				mag_q <= mag_gain[EnvW-1:0];
				neg_q <= x_raw[SampleW-1];
			end
			ST_ENV: env_new_q <= env_new;
			ST_CMP: begin
				rem_q <= {1'b0, EnvW'(thr_q)};
				quo_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				// restoring divide of thr * 2^24 by env, one bit a cycle
				if (rem_sh >= {1'b0, env_new_q}) begin
					rem_q <= rem_sh - {1'b0, env_new_q};
					quo_q <= {quo_q[DivW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[DivW-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 5'd1;
			end
			ST_SCALE: mag_q <= scaled[EnvW-1:0];
			ST_GAIN_OUT: begin
				if (ch_q) begin
					if (out_free) out_q <= '{left_out: res0_q, right_out: y_sat};
				end else begin
					res0_q <= y_sat;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ----- rtl/core/spl_checker.sv -----
// port-level checker for the stereo peak limiter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module spl_checker
	import spl_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_item_t out_item
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("output item changed under stall");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted two items back to back");
	a_gap_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("result offered twice");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall [*9])
		else $error("item finished too early");
endmodule

bind stereo_peak_limiter_unit spl_checker u_spl_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
`default_nettype wire

// ----- test/tb.sv -----
// testbench for the stereo peak limiter: directed table, random items and a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import spl_pkg::*;

	localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = REG_INPUT_GAIN;
	logic [RegW-1:0] cfg_data = '0;

	stereo_peak_limiter_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("tb: FAIL");
		$finish;
	end

	// predictor state
	logic [23:0] gain_in_q, gain_out_q, thr_q, att_q, rel_q;
	logic [27:0] env_q [2];
	out_item_t limited_q [$];
	int errors = 0;
	int recv_wait = 0;
	bit recv_on = 1'b0;

	function automatic logic [23:0] limit_sample(int ch, logic [23:0] x);
		logic neg;
		logic [63:0] mag, env, thr, ratio, y;
		neg = x[23];
		mag = neg ? (64'd16777216 - {40'd0, x}) : {40'd0, x};
		env = {36'd0, env_q[ch]};
		thr = {40'd0, thr_q};
		mag = (mag * gain_in_q + 64'd524288) >> 20;
		if (mag > env)
			env = mag - ((att_q * (mag - env) + 64'd8388608) >> 24);
		else
			env = mag + ((rel_q * (env - mag) + 64'd8388608) >> 24);
		env = env & 64'hFFFFFFF;
		env_q[ch] = env[27:0];
		if (env > thr) begin
			ratio = (thr << 24) / env;
			mag = (mag * ratio + 64'd8388608) >> 24;
		end
		y = (mag * gain_out_q + 64'd524288) >> 20;
		if (neg) begin
			if (y > 64'd8388608)
				y = 64'd8388608;
			return 24'(64'd16777216 - y);
		end
		if (y > 64'd8388607)
			y = 64'd8388607;
		return y[23:0];
	endfunction

	function automatic out_item_t predict_frame(in_item_t f);
		out_item_t r;
		r.left_out = limit_sample(0, f.left_in);
		r.right_out = limit_sample(1, f.right_in);
		return r;
	endfunction

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_INPUT_GAIN:  gain_in_q = val;
			REG_OUTPUT_GAIN: gain_out_q = val;
			REG_THRESHOLD:   thr_q = val;
			REG_ATTACK:      att_q = val;
			REG_RELEASE:     rel_q = val;
			default: ;
		endcase
	endtask

	task automatic send_frame(in_item_t f, bit typed, out_item_t want);
		int gap;
		out_item_t p;
		gap = $urandom_range(0, 12);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= f;
		do @(posedge clk); while (in_stall);
		p = predict_frame(f);
		limited_q.push_back(typed ? want : p);
	endtask

	task automatic drain;
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (limited_q.size() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		repeat (100) @(posedge clk);
	endtask

	// receiver with random waits per item
	always @(posedge clk) begin
		out_item_t w;
		if (recv_on) begin
			if (out_valid && !out_stall) begin
				if (limited_q.size() == 0) begin
					$display("%0t unexpected item %h", $time, out_item);
					errors++;
				end else begin
					w = limited_q.pop_front();
					if (w.left_out !== out_item.left_out) begin
						$display("%0t left_out expected %h actual %h", $time,
							w.left_out, out_item.left_out);
						errors++;
					end
					if (w.right_out !== out_item.right_out) begin
						$display("%0t right_out expected %h actual %h", $time,
							w.right_out, out_item.right_out);
						errors++;
					end
				end
				recv_wait = $urandom_range(0, 12);
			end else if (recv_wait != 0) begin
				recv_wait = recv_wait - 1;
			end
			out_stall <= (recv_wait != 0);
		end
	end

	typedef struct {
		logic [23:0] l;
		logic [23:0] r;
		bit typed;
		logic [23:0] wl;
		logic [23:0] wr;
	} row_t;

	row_t dir_rows [] = '{
		'{24'd0, 24'd0, 1, 24'd0, 24'd0},
		'{24'h7FFFFF, 24'h800000, 0, 0, 0},
		'{24'h800000, 24'h7FFFFF, 0, 0, 0},
		'{24'd1, 24'hFFFFFF, 0, 0, 0},
		'{24'h400000, 24'hC00000, 0, 0, 0},
		'{24'h555555, 24'hAAAAAA, 0, 0, 0},
		'{24'd0, 24'd0, 0, 0, 0}
	};

	task automatic run_table;
		foreach (dir_rows[i])
			send_frame('{dir_rows[i].l, dir_rows[i].r}, dir_rows[i].typed,
				'{dir_rows[i].wl, dir_rows[i].wr});
	endtask

	task automatic random_phase(int n);
		in_item_t f;
		int k;
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 3))
				0: f = '{24'($urandom), 24'($urandom)};
				1: f = '{24'($urandom_range(0, 4095)) ^ {24{$urandom_range(0,1) == 1}},
					24'($urandom_range(0, 4095))};
				2: f = '{$urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000,
					$urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF};
				default: f = '{24'($urandom) >>> $urandom_range(0, 20),
					24'($urandom) >>> $urandom_range(0, 20)};
			endcase
			send_frame(f, 0, '0);
		end
	endtask

	initial begin
		gain_in_q = 24'd1048576;
		gain_out_q = 24'd1048576;
		thr_q = 24'd7919344;
		att_q = 24'd16617027;
		rel_q = 24'd16773997;
		env_q[0] = '0;
		env_q[1] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		recv_on <= 1'b1;
		@(posedge clk);
		run_table();
		random_phase(300);
		drain();
		// extremes: full gains, zero threshold, no smoothing
		write_reg(REG_INPUT_GAIN, 24'hFFFFFF);
		write_reg(REG_OUTPUT_GAIN, 24'hFFFFFF);
		write_reg(REG_THRESHOLD, 24'd0);
		write_reg(REG_ATTACK, 24'd0);
		write_reg(REG_RELEASE, 24'd0);
		write_reg(REG_UNUSED, 24'h123456);
		send_frame('{24'h7FFFFF, 24'h800000}, 1, '{24'd0, 24'd0});
		random_phase(200);
		drain();
		// threshold above full scale, slow envelope
		write_reg(REG_INPUT_GAIN, 24'd0);
		send_frame('{24'h7FFFFF, 24'h800000}, 0, '0);
		drain();
		write_reg(REG_INPUT_GAIN, 24'd4194304);
		write_reg(REG_OUTPUT_GAIN, 24'd0);
		write_reg(REG_THRESHOLD, 24'hFFFFFF);
		write_reg(REG_ATTACK, 24'hFFFFFF);
		write_reg(REG_RELEASE, 24'hFFFFFF);
		random_phase(200);
		drain();
		repeat (3) begin
			write_reg(REG_INPUT_GAIN, 24'($urandom_range(0, 24'h3FFFFF)));
			write_reg(REG_OUTPUT_GAIN, 24'($urandom_range(0, 24'h3FFFFF)));
			write_reg(REG_THRESHOLD, 24'($urandom_range(1, 8388608)));
			write_reg(REG_ATTACK, 24'($urandom));
			write_reg(REG_RELEASE, 24'($urandom));
			random_phase(330);
			drain();
		end
		if (errors == 0 && limited_q.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/spl_pkg.sv
rtl/core/stereo_peak_limiter_unit.sv
rtl/core/spl_checker.sv
test/tb.sv
